>>> hw/rtl/button_debounce_long_press_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce / long press block
// Clocked concurrent assertion forms, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Generic clocked property.
`define BDLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication.
`define BDLP_ASSERT_IMPL(label, ante, cons, msg) \
    `BDLP_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
    `BDLP_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce / long press block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_LONG     = 3'd2,
        EV_REL_LONG = 3'd3,
        EV_RELEASED = 3'd4
    } event_t;

    localparam int unsigned CH_FIELD_W   = 3;
    localparam int unsigned TICK_W       = 32;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned S_TDATA_W    = 40;
    localparam int unsigned M_TDATA_W    = 8;
    localparam int unsigned M_TUSER_W    = 3;

    // register select is paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_LONG     = 1'b1;

    localparam logic [APB_ADDR_W-1:0] ADDR_DEBOUNCE = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_LONG     = 3'd4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd15;
    localparam logic [CFG_W-1:0] LONG_RESET     = 16'd300;

endpackage

`default_nettype wire

>>> hw/rtl/button_debounce_long_press.sv
// An accepted input beat passes the input stage register, then the output
// register. Throughput: one beat per cycle while the output is not stalled; the
// per-channel state is read and written back in the same cycle, so polls of the
// same channel may follow each other. Output register decouples the stream
// sides; a stalled output stalls input only once the input stage is full too.
// Reset: all channel state and both stages clear; config returns to 15 / 300.
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Per-channel stable-confirm debouncer with press / long press / release
// event reporting, one poll per input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press #(
    parameter int unsigned CHANNELS = 4
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // APB config port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [bdlp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [bdlp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bdlp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // poll stream
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] channel, [3] raw_pressed, [35:4] now_tick, [39:36] zero
    input  wire  [bdlp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [0] debounced_level, [7:1] zero
    output logic [bdlp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [2:0] event_res
    output logic [bdlp_pkg::M_TUSER_W-1:0]     m_axis_tuser
);
    import bdlp_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            long_reg     <= LONG_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_DEBOUNCE)
                debounce_reg <= pwdata[CFG_W-1:0];
            else
                long_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_DEBOUNCE)
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, debounce_reg};
        else
            prdata = {{(APB_DATA_W-CFG_W){1'b0}}, long_reg};
    end

    // ---------------- input stage ----------------
    logic                  in_valid_reg;
    logic [CH_FIELD_W-1:0] in_ch_reg;
    logic                  in_raw_reg;
    logic [TICK_W-1:0]     in_now_reg;

    logic out_valid_reg;
    logic out_free;
    logic advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ch_reg  <= s_axis_tdata[2:0];
            in_raw_reg <= s_axis_tdata[3];
            in_now_reg <= s_axis_tdata[35:4];
        end
    end

    // ---------------- per-channel state ----------------
    logic [CHANNELS-1:0] cand_level_reg;
    logic [TICK_W-1:0]   cand_since_reg [CHANNELS];
    logic [CHANNELS-1:0] conf_level_reg;
    logic [CHANNELS-1:0] prev_level_reg;
    logic [CHANNELS-1:0] long_seen_reg;
    logic [TICK_W-1:0]   press_start_reg [CHANNELS];

    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic              cand_level;
    logic [TICK_W-1:0] cand_since;
    logic              conf_level;
    logic              prev_level;
    logic              long_seen;
    logic [TICK_W-1:0] press_start;

    logic              cand_level_next;
    logic [TICK_W-1:0] cand_since_next;
    logic              conf_level_next;
    logic              long_seen_next;
    logic [TICK_W-1:0] press_start_next;
    logic [TICK_W-1:0] settle;
    logic [TICK_W-1:0] held;
    logic              long_hit;
    event_t            ev;

    assign in_range = {1'b0, in_ch_reg} < (CH_FIELD_W+1)'(CHANNELS);
    assign idx      = in_ch_reg[IDX_W-1:0];

    assign cand_level  = cand_level_reg[idx];
    assign cand_since  = cand_since_reg[idx];
    assign conf_level  = conf_level_reg[idx];
    assign prev_level  = prev_level_reg[idx];
    assign long_seen   = long_seen_reg[idx];
    assign press_start = press_start_reg[idx];

    assign settle   = in_now_reg - cand_since;
    assign held     = in_now_reg - press_start;
    assign long_hit = held >= {{(TICK_W-CFG_W){1'b0}}, long_reg};

    always_comb
    begin
        cand_level_next  = cand_level;
        cand_since_next  = cand_since;
        conf_level_next  = conf_level;
        long_seen_next   = long_seen;
        press_start_next = press_start;
        ev               = EV_NONE;

        // a new raw level restarts the settle window
        if (in_raw_reg != cand_level)
        begin
            cand_level_next = in_raw_reg;
            cand_since_next = in_now_reg;
        end
        else if (settle >= {{(TICK_W-CFG_W){1'b0}}, debounce_reg})
        begin
            conf_level_next = in_raw_reg;
        end

        priority if (!prev_level && conf_level_next)
        begin
            press_start_next = in_now_reg;
            long_seen_next   = 1'b0;
            ev               = EV_PRESSED;
        end
        else if (prev_level && conf_level_next)
        begin
            if (!long_seen && long_hit)
            begin
                long_seen_next = 1'b1;
                ev             = EV_LONG;
            end
        end
        else if (prev_level && !conf_level_next)
        begin
            long_seen_next = 1'b0;
            ev             = long_hit ? EV_REL_LONG : EV_RELEASED;
        end
        else
        begin
            ev = EV_NONE;
        end

        if (!in_range)
            ev = EV_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_level_reg <= '0;
            conf_level_reg <= '0;
            prev_level_reg <= '0;
            long_seen_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cand_since_reg[i]  <= '0;
                press_start_reg[i] <= '0;
            end
        end
        else if (advance && in_range)
        begin
            cand_level_reg[idx]  <= cand_level_next;
            cand_since_reg[idx]  <= cand_since_next;
            conf_level_reg[idx]  <= conf_level_next;
            prev_level_reg[idx]  <= conf_level_next;
            long_seen_reg[idx]   <= long_seen_next;
            press_start_reg[idx] <= press_start_next;
        end
    end

    // ---------------- output register ----------------
    logic   out_valid_next;
    event_t out_event_reg;
    logic   out_level_reg;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= ev;
            out_level_reg <= in_range && conf_level_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_level_reg};
    assign m_axis_tuser  = out_event_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks for button_debounce_long_press, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_long_press_macros.svh"

module bdlp_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              psel,
    input wire                              penable,
    input wire                              pwrite,
    input wire [bdlp_pkg::APB_ADDR_W-1:0]   paddr,
    input wire [bdlp_pkg::APB_DATA_W-1:0]   pwdata,
    input wire [bdlp_pkg::APB_DATA_W-1:0]   prdata,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [bdlp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input wire [bdlp_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import bdlp_pkg::*;

    logic                                      out_stall;
    logic [M_TUSER_W+M_TDATA_W:0]              out_word;
    logic                                      press_beat;
    logic                                      release_beat;
    logic                                      deb_addr;
    logic                                      deb_write;
    logic [APB_DATA_W-1:0]                     deb_word;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_word     = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
    assign press_beat   = m_axis_tvalid
                          && (m_axis_tuser == EV_PRESSED || m_axis_tuser == EV_LONG);
    assign release_beat = m_axis_tvalid
                          && (m_axis_tuser == EV_RELEASED || m_axis_tuser == EV_REL_LONG);
    assign deb_addr     = (paddr == ADDR_DEBOUNCE);
    assign deb_write    = psel && penable && pwrite && deb_addr;
    assign deb_word     = {{(APB_DATA_W-CFG_W){1'b0}}, pwdata[CFG_W-1:0]};

    // stalled result beat holds
    `BDLP_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "stalled beat changed")

    // press and long press are only reported with the level high
    `BDLP_ASSERT_IMPL(a_press_level, press_beat, m_axis_tdata[0], "press with level low")

    // releases are only reported with the level low
    `BDLP_ASSERT_IMPL(a_release_level, release_beat, !m_axis_tdata[0], "release with level high")

    // debounce time reads back what was just written
    `BDLP_ASSERT_NEXT(a_readback, deb_write, !deb_addr || prdata == $past(deb_word), "bad readback")

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (.*);

`default_nettype wire

>>> verif/button_debounce_long_press_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// Self-checking bench for the per-channel debouncer with long press events.
// A short table of hand-built polls covers bounce, wrap of the tick counter,
// zero and maximum timing settings and out-of-range channels. Random press
// gestures and noise then run under several timing settings. Every result
// beat is checked against the result its row carries or a behavioral model of
// the debouncer kept in this file. Both stream sides idle at random, and the
// result side holds off once for a long stretch so the block stalls its input.
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb;
    import bdlp_pkg::*;

    localparam int unsigned NUM_CH         = 4;
    localparam int unsigned DIR_ROWS       = 25;
    localparam int unsigned RAND_POLLS     = 530;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned HOLDOFF_AFTER  = 200;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

    typedef struct packed {
        event_t ev;
        logic   lvl;
    } poll_result_t;

    // typed: the row carries its own expected result
    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  ch;
        logic        raw;
        logic [31:0] tick;
        logic        typed;
        event_t      ev;
        logic        lvl;
        logic [15:0] deb;
        logic [15:0] lng;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [2:0] channel, [3] raw_pressed, [35:4] now_tick, [39:36] zero
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] debounced_level, [7:1] zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // [2:0] event_res
    logic [M_TUSER_W-1:0]  m_axis_tuser;

    button_debounce_long_press #(
        .CHANNELS (NUM_CH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // debouncer model state
    logic        cand_lvl  [NUM_CH];
    logic [31:0] cand_t    [NUM_CH];
    logic        conf_lvl  [NUM_CH];
    logic        last_lvl  [NUM_CH];
    logic        long_seen [NUM_CH];
    logic [31:0] press_t   [NUM_CH];
    logic [15:0] settle_ticks;
    logic [15:0] hold_ticks;

    poll_result_t due_results [$];

    int unsigned polls_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned ev_count [0:4];
    int unsigned tx_burst;
    logic        holdoff_done;
    logic [31:0] run_tick;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // after reset, and channels past the last one
        '{ROW_POLL, 3'd0, 1'b0, 32'h0000_0000, 1'b1, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd4, 1'b1, 32'h0000_0064, 1'b1, EV_NONE, 1'b0, 16'd0, 16'd0},
        // press, long press once, release after long
        '{ROW_POLL, 3'd0, 1'b1, 32'd10,  1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd0, 1'b1, 32'd25,  1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd0, 1'b1, 32'd324, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd0, 1'b1, 32'd325, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd0, 1'b1, 32'd400, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd0, 1'b0, 32'd410, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd0, 1'b0, 32'd425, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        // settle window across the tick wrap, bounce, short release
        '{ROW_POLL, 3'd1, 1'b1, 32'hFFFF_FFF8, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd1, 1'b1, 32'h0000_0007, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd1, 1'b0, 32'h0000_0020, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd1, 1'b1, 32'h0000_0028, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd1, 1'b0, 32'h0000_0030, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd1, 1'b0, 32'h0000_003F, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        // no settle time; release counts as long with no long event seen
        '{ROW_CFG,  3'd0, 1'b0, 32'd0, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd300},
        '{ROW_POLL, 3'd2, 1'b1, 32'd5,    1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd2, 1'b1, 32'd5,    1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd2, 1'b0, 32'd6,    1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd2, 1'b0, 32'd1000, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        // longest settle, zero long press time
        '{ROW_CFG,  3'd0, 1'b0, 32'd0, 1'b0, EV_NONE, 1'b0, 16'd65535, 16'd0},
        '{ROW_POLL, 3'd3, 1'b1, 32'h0000_0000, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd3, 1'b1, 32'h0000_FFFF, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0},
        '{ROW_POLL, 3'd3, 1'b1, 32'h0000_FFFF, 1'b0, EV_NONE, 1'b0, 16'd0, 16'd0}
    };

    logic [15:0] phase_deb [6] = '{16'd15, 16'd0, 16'd65535, 16'd3, 16'd0, 16'd65535};
    logic [15:0] phase_lng [6] = '{16'd300, 16'd0, 16'd65535, 16'd40, 16'd65535, 16'd0};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(64'd20_000_000);
        $display("FAIL button_debounce_long_press");
        $finish;
    end

    // one poll through the debouncer and edge machine; updates model state
    function automatic poll_result_t debounce_poll(input logic [2:0] ch, input logic raw,
                                                   input logic [31:0] tick);
        poll_result_t res;
        logic [31:0]  held;
        logic         cur;
        logic         prev;
        int           idx;
        res.ev  = EV_NONE;
        res.lvl = 1'b0;
        if (ch >= NUM_CH)
            return res;
        idx = int'(ch);
        if (raw != cand_lvl[idx])
        begin
            cand_lvl[idx] = raw;
            cand_t[idx]   = tick;
        end
        else if (tick - cand_t[idx] >= {16'd0, settle_ticks})
            conf_lvl[idx] = raw;
        cur  = conf_lvl[idx];
        prev = last_lvl[idx];
        held = tick - press_t[idx];
        if (!prev && cur)
        begin
            press_t[idx]   = tick;
            long_seen[idx] = 1'b0;
            res.ev         = EV_PRESSED;
        end
        else if (prev && cur)
        begin
            if (!long_seen[idx] && held >= {16'd0, hold_ticks})
            begin
                long_seen[idx] = 1'b1;
                res.ev         = EV_LONG;
            end
        end
        else if (prev && !cur)
        begin
            long_seen[idx] = 1'b0;
            res.ev = (held >= {16'd0, hold_ticks}) ? EV_REL_LONG : EV_RELEASED;
        end
        last_lvl[idx] = cur;
        res.lvl = cur;
        return res;
    endfunction

    function automatic int unsigned pick_tx_gap();
        int unsigned r;
        if (tx_burst != 0)
        begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 8)
        begin
            tx_burst = $urandom_range(40, 10);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic send_poll(input logic [2:0] ch, input logic raw, input logic [31:0] tick,
                             input logic typed, input poll_result_t typed_res);
        int unsigned  gap;
        poll_result_t want;
        gap = pick_tx_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, tick, raw, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = debounce_poll(ch, raw, tick);
        due_results.push_back(typed ? typed_res : want);
        polls_sent++;
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // timing registers change only with the block drained
    task automatic set_timing(input logic [15:0] deb, input logic [15:0] lng);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_write(ADDR_DEBOUNCE, deb);
        settle_ticks = deb;
        apb_write(ADDR_LONG, lng);
        hold_ticks = lng;
    endtask

    // result side: random ready, one long hold-off once traffic is flowing
    initial
    begin
        int unsigned run;
        logic        lvl;
        m_axis_tready <= 1'b0;
        run = 0;
        lvl = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!holdoff_done && results_seen >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (run == 0)
                begin
                    lvl = !lvl;
                    if (lvl)
                        run = ($urandom_range(9) == 0) ? $urandom_range(150, 60)
                                                        : $urandom_range(20, 1);
                    else if ($urandom_range(19) == 0)
                        run = $urandom_range(50, 20);
                    else
                        run = $urandom_range(4, 1);
                end
                m_axis_tready <= lvl;
                run--;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        poll_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $error("result beat with nothing pending: event_res %0d debounced_level %0d",
                       m_axis_tuser, m_axis_tdata[0]);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                ev_count[want.ev]++;
                if (m_axis_tuser !== want.ev)
                begin
                    $error("event_res mismatch: expected %0d actual %0d", want.ev, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[0] !== want.lvl)
                begin
                    $error("debounced_level mismatch: expected %0d actual %0d",
                           want.lvl, m_axis_tdata[0]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int unsigned  ph;
        int unsigned  phase_goal;
        int unsigned  n;
        int unsigned  settle;
        int unsigned  span;
        logic [2:0]   ch;
        logic [31:0]  noise_tick;
        logic [15:0]  deb;
        logic [15:0]  lng;
        poll_result_t typed_res;
        dir_row_t     row;

        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            cand_lvl[i]  = 1'b0;
            cand_t[i]    = '0;
            conf_lvl[i]  = 1'b0;
            last_lvl[i]  = 1'b0;
            long_seen[i] = 1'b0;
            press_t[i]   = '0;
        end
        for (int i = 0; i < 5; i++)
            ev_count[i] = 0;
        settle_ticks = DEBOUNCE_RESET;
        hold_ticks   = LONG_RESET;
        polls_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        tx_burst     = 0;
        holdoff_done = 1'b0;
        run_tick     = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                set_timing(row.deb, row.lng);
            else
            begin
                typed_res.ev  = row.ev;
                typed_res.lvl = row.lvl;
                send_poll(row.ch, row.raw, row.tick, row.typed, typed_res);
            end
        end

        typed_res = '0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 6)
            begin
                deb = phase_deb[ph];
                lng = phase_lng[ph];
            end
            else
            begin
                deb = 16'($urandom_range(200));
                lng = 16'($urandom_range(2000));
            end
            set_timing(deb, lng);
            settle = settle_ticks;
            span   = hold_ticks;
            phase_goal = polls_sent + RAND_POLLS / PHASES;
            while (polls_sent < phase_goal)
            begin
                if ($urandom_range(9) < 7)
                begin
                    // full gesture: bounce, settle, hold, bounce, settle
                    ch = 3'($urandom_range(NUM_CH - 1));
                    n = $urandom_range(3);
                    repeat (n)
                    begin
                        run_tick += $urandom_range(settle / 2 + 1);
                        send_poll(ch, 1'($urandom_range(1)), run_tick, 1'b0, typed_res);
                    end
                    run_tick += 1;
                    send_poll(ch, 1'b1, run_tick, 1'b0, typed_res);
                    run_tick += settle + $urandom_range(2);
                    send_poll(ch, 1'b1, run_tick, 1'b0, typed_res);
                    n = $urandom_range(5, 1);
                    repeat (n)
                    begin
                        run_tick += $urandom_range(span / 2 + 2);
                        send_poll(ch, 1'b1, run_tick, 1'b0, typed_res);
                    end
                    n = $urandom_range(3);
                    repeat (n)
                    begin
                        run_tick += $urandom_range(settle / 2 + 1);
                        send_poll(ch, 1'($urandom_range(1)), run_tick, 1'b0, typed_res);
                    end
                    run_tick += 1;
                    send_poll(ch, 1'b0, run_tick, 1'b0, typed_res);
                    run_tick += settle + $urandom_range(2);
                    send_poll(ch, 1'b0, run_tick, 1'b0, typed_res);
                end
                else
                begin
                    n = $urandom_range(3, 1);
                    repeat (n)
                    begin
                        if ($urandom_range(9) == 0)
                            noise_tick = $urandom;
                        else
                            noise_tick = run_tick + $urandom_range(50);
                        send_poll(3'($urandom_range(7)), 1'($urandom_range(1)), noise_tick,
                                  1'b0, typed_res);
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d polls (%0d timing settings in the random part), checked %0d results.",
                 polls_sent, PHASES, results_seen);
        $display("Events: none %0d, pressed %0d, long %0d, release after long %0d, release %0d.",
                 ev_count[0], ev_count[1], ev_count[2], ev_count[3], ev_count[4]);
        if (mismatches == 0 && due_results.size() == 0)
            $display("PASS button_debounce_long_press");
        else
            $display("FAIL button_debounce_long_press");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bdlp_pkg.sv
hw/rtl/button_debounce_long_press.sv
hw/rtl/bdlp_checker.sv
verif/button_debounce_long_press_tb.sv
